>>> rtl/nps_pkg.sv
`timescale 1ns / 1ps
package nps_pkg;

	localparam int NPS_WIDTH = 32;
	localparam int NPS_VW    = (NPS_WIDTH < 32) ? NPS_WIDTH : 32;
	localparam int NPS_DW    = NPS_VW / 2 + 2;
	localparam int NPS_SQW   = 2 * NPS_DW;
	localparam int NPS_CW    = $clog2(NPS_VW + 1);
	localparam int NPS_PC_W  = 5;

	localparam logic [31:0] NPS_BOUND = 32'((64'd1 << NPS_VW) - 64'd1);

	localparam logic [NPS_DW-1:0] NPS_D_FIRST   = NPS_DW'(5);
	localparam logic [NPS_DW-1:0] NPS_D_PAIR    = NPS_DW'(2);
	localparam logic [NPS_DW-1:0] NPS_D_STEP    = NPS_DW'(6);
	localparam logic [NPS_VW-1:0] NPS_SMALL_PRIME_MAX = NPS_VW'(3);

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT_CAND,
		OP_INC_CAND,
		OP_SET_D5,
		OP_SQ,
		OP_DIV_D,
		OP_DIV_D2,
		OP_ADD_D6,
		OP_EMIT_PRIME,
		OP_EMIT_TWO,
		OP_EMIT_OVF
	} nps_op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_IN,
		C_START_LE1,
		C_START_GE_BOUND,
		C_CAND_LE3,
		C_CAND_EVEN,
		C_CAND_MOD3,
		C_CAND_AT_BOUND,
		C_DIV_BUSY,
		C_REM_ZERO,
		C_SQ_GT,
		C_OUT_FULL
	} nps_cond_t;

	typedef struct packed {
		nps_op_t               op;
		nps_cond_t             cond;
		logic [NPS_PC_W-1:0]   target;
	} nps_ctrl_t;

	typedef struct packed {
		logic no_in;
		logic start_le1;
		logic start_ge_bound;
		logic cand_le3;
		logic cand_even;
		logic cand_mod3_zero;
		logic cand_at_bound;
		logic div_busy;
		logic rem_zero;
		logic sq_gt;
		logic out_full;
	} nps_flags_t;

	localparam logic [NPS_PC_W-1:0] L_FETCH = NPS_PC_W'(0);
	localparam logic [NPS_PC_W-1:0] L_TEST  = NPS_PC_W'(4);
	localparam logic [NPS_PC_W-1:0] L_LOOP  = NPS_PC_W'(8);
	localparam logic [NPS_PC_W-1:0] L_NEXT  = NPS_PC_W'(17);
	localparam logic [NPS_PC_W-1:0] L_PRIME = NPS_PC_W'(19);
	localparam logic [NPS_PC_W-1:0] L_TWO   = NPS_PC_W'(21);
	localparam logic [NPS_PC_W-1:0] L_OVF   = NPS_PC_W'(23);

	function automatic nps_ctrl_t nps_uw(input nps_op_t op, input nps_cond_t cond,
		input logic [NPS_PC_W-1:0] target);
		nps_ctrl_t w;
		w.op     = op;
		w.cond   = cond;
		w.target = target;
		return w;
	endfunction

	// microcode store: jump to target when cond holds, else step on
	function automatic nps_ctrl_t nps_ucode(input logic [NPS_PC_W-1:0] pc);
		nps_ctrl_t w;
		unique case (pc)
			5'd0:    w = nps_uw(OP_LOAD,       C_NO_IN,          L_FETCH);
			5'd1:    w = nps_uw(OP_NONE,       C_START_LE1,      L_TWO);
			5'd2:    w = nps_uw(OP_NONE,       C_START_GE_BOUND, L_OVF);
			5'd3:    w = nps_uw(OP_INIT_CAND,  C_NEVER,          L_FETCH);
			5'd4:    w = nps_uw(OP_NONE,       C_CAND_LE3,       L_PRIME);
			5'd5:    w = nps_uw(OP_NONE,       C_CAND_EVEN,      L_NEXT);
			5'd6:    w = nps_uw(OP_NONE,       C_CAND_MOD3,      L_NEXT);
			5'd7:    w = nps_uw(OP_SET_D5,     C_NEVER,          L_FETCH);
			5'd8:    w = nps_uw(OP_SQ,         C_NEVER,          L_FETCH);
			5'd9:    w = nps_uw(OP_NONE,       C_SQ_GT,          L_PRIME);
			5'd10:   w = nps_uw(OP_DIV_D,      C_NEVER,          L_FETCH);
			5'd11:   w = nps_uw(OP_NONE,       C_DIV_BUSY,       NPS_PC_W'(11));
			5'd12:   w = nps_uw(OP_NONE,       C_REM_ZERO,       L_NEXT);
			5'd13:   w = nps_uw(OP_DIV_D2,     C_NEVER,          L_FETCH);
			5'd14:   w = nps_uw(OP_NONE,       C_DIV_BUSY,       NPS_PC_W'(14));
			5'd15:   w = nps_uw(OP_NONE,       C_REM_ZERO,       L_NEXT);
			5'd16:   w = nps_uw(OP_ADD_D6,     C_ALWAYS,         L_LOOP);
			5'd17:   w = nps_uw(OP_NONE,       C_CAND_AT_BOUND,  L_OVF);
			5'd18:   w = nps_uw(OP_INC_CAND,   C_ALWAYS,         L_TEST);
			5'd19:   w = nps_uw(OP_EMIT_PRIME, C_OUT_FULL,       L_PRIME);
			5'd20:   w = nps_uw(OP_NONE,       C_ALWAYS,         L_FETCH);
			5'd21:   w = nps_uw(OP_EMIT_TWO,   C_OUT_FULL,       L_TWO);
			5'd22:   w = nps_uw(OP_NONE,       C_ALWAYS,         L_FETCH);
			5'd23:   w = nps_uw(OP_EMIT_OVF,   C_OUT_FULL,       L_OVF);
			default: w = nps_uw(OP_NONE,       C_ALWAYS,         L_FETCH);
		endcase
		return w;
	endfunction

endpackage

>>> rtl/nps_in_if.sv
`timescale 1ns / 1ps
interface nps_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] start_value;

	modport source(output valid, output start_value, input ready);
	modport sink(input valid, input start_value, output ready);
endinterface

>>> rtl/nps_out_if.sv
`timescale 1ns / 1ps
interface nps_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] next_prime;
	logic        overflow;

	modport source(output valid, output next_prime, output overflow, input ready);
	modport sink(input valid, input next_prime, input overflow, output ready);
endinterface

>>> rtl/next_prime_search_unit.sv
`timescale 1ns / 1ps
// returns the smallest prime above each start value (2 for start values of 0 and 1, zero
// with overflow set when none fits); one item is searched at a time, but the next item is
// taken while a result still waits in the output register; a candidate that is even or a
// multiple of three is dropped before any trial division, and otherwise it is tried
// against the pairs 6k-1, 6k+1 while (6k-1)^2 does not exceed it, each divide done by the
// serial remainder unit, one quotient bit per cycle, run by the microcode sequencer
module next_prime_search_unit (
	input  logic      clk,
	input  logic      arst_n,
	nps_in_if.sink    start_ch,
	nps_out_if.source result_ch
);
	import nps_pkg::*;

	nps_ctrl_t  ctrl;
	nps_flags_t flags;

	nps_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	nps_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_ch  (start_ch),
		.result_ch (result_ch),
		.ctrl      (ctrl),
		.flags     (flags)
	);
endmodule

>>> rtl/nps_rem_unit.sv
`timescale 1ns / 1ps
module nps_rem_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [nps_pkg::NPS_VW-1:0] dividend,
	input  logic [nps_pkg::NPS_DW-1:0] divisor,
	output logic                       busy,
	output logic                       rem_zero
);
	import nps_pkg::*;

	logic              busy_q;
	logic [NPS_CW-1:0] cnt_q;
	logic [NPS_VW-1:0] num_q;
	logic [NPS_DW-1:0] den_q;
	logic [NPS_DW-1:0] rem_q;
	logic [NPS_DW:0]   trial;
	logic [NPS_DW:0]   diff;
	logic              ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, num_q[NPS_VW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= NPS_CW'(NPS_VW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - NPS_CW'(1);
			if (cnt_q == NPS_CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? diff[NPS_DW-1:0] : trial[NPS_DW-1:0];
		end
	end

	assign busy     = busy_q;
	assign rem_zero = (rem_q == '0);

	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> busy_q)
		else $error("remainder unit not busy after start");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (rem_q < den_q))
		else $error("remainder not below divisor");
endmodule

>>> rtl/nps_useq.sv
`timescale 1ns / 1ps
module nps_useq (
	input  logic                clk,
	input  logic                arst_n,
	input  nps_pkg::nps_flags_t flags,
	output nps_pkg::nps_ctrl_t  ctrl
);
	import nps_pkg::*;

	logic [NPS_PC_W-1:0] pc_q;
	logic                hit;

	assign ctrl = nps_ucode(pc_q);

	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:          hit = 1'b0;
			C_ALWAYS:         hit = 1'b1;
			C_NO_IN:          hit = flags.no_in;
			C_START_LE1:      hit = flags.start_le1;
			C_START_GE_BOUND: hit = flags.start_ge_bound;
			C_CAND_LE3:       hit = flags.cand_le3;
			C_CAND_EVEN:      hit = flags.cand_even;
			C_CAND_MOD3:      hit = flags.cand_mod3_zero;
			C_CAND_AT_BOUND:  hit = flags.cand_at_bound;
			C_DIV_BUSY:       hit = flags.div_busy;
			C_REM_ZERO:       hit = flags.rem_zero;
			C_SQ_GT:          hit = flags.sq_gt;
			C_OUT_FULL:       hit = flags.out_full;
			default:          hit = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= L_FETCH;
		end else begin
			pc_q <= hit ? ctrl.target : pc_q + NPS_PC_W'(1);
		end
	end
endmodule

>>> rtl/nps_datapath.sv
`timescale 1ns / 1ps
module nps_datapath (
	input  logic                clk,
	input  logic                arst_n,
	nps_in_if.sink              start_ch,
	nps_out_if.source           result_ch,
	input  nps_pkg::nps_ctrl_t  ctrl,
	output nps_pkg::nps_flags_t flags
);
	import nps_pkg::*;

	logic [31:0]        start_q;
	logic [NPS_VW-1:0]  cand_q;
	logic [NPS_DW-1:0]  d_q;
	logic [NPS_SQW-1:0] sq_q;
	logic [NPS_SQW-1:0] sq_d;
	logic               out_valid_q;
	logic [31:0]        prime_q;
	logic               ovf_q;

	logic               accept;
	logic               out_full;
	logic               out_we;
	logic               div_go;
	logic [NPS_DW-1:0]  divisor;
	logic               div_busy;
	logic               rem_zero;

	// multiple of three: fold digit groups, since 2^16, 2^8, 2^4 and 2^2 are all 1 mod 3
	function automatic logic nps_mod3_zero(input logic [31:0] v);
		logic [16:0] f16;
		logic [9:0]  f8;
		logic [5:0]  f4;
		logic [4:0]  f2a;
		logic [2:0]  f2b;
		f16 = {1'b0, v[31:16]} + {1'b0, v[15:0]};
		f8  = 10'(f16[16:8]) + 10'(f16[7:0]);
		f4  = 6'(f8[9:4]) + 6'(f8[3:0]);
		f2a = 5'(f4[5:2]) + 5'(f4[1:0]);
		f2b = 3'(f2a[4:2]) + 3'(f2a[1:0]);
		return (f2b == 3'd0) || (f2b == 3'd3) || (f2b == 3'd6);
	endfunction

	assign start_ch.ready = (ctrl.op == OP_LOAD);
	assign accept         = start_ch.valid && start_ch.ready;
	assign out_full       = out_valid_q && !result_ch.ready;
	assign out_we         = !out_full && ((ctrl.op == OP_EMIT_PRIME) ||
		(ctrl.op == OP_EMIT_TWO) || (ctrl.op == OP_EMIT_OVF));
	assign div_go         = (ctrl.op == OP_DIV_D) || (ctrl.op == OP_DIV_D2);
	assign sq_d           = NPS_SQW'(d_q) * NPS_SQW'(d_q);

	always_comb begin
		unique case (ctrl.op)
			OP_DIV_D2: divisor = d_q + NPS_D_PAIR;
			default:   divisor = d_q;
		endcase
	end

	nps_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (cand_q),
		.divisor  (divisor),
		.busy     (div_busy),
		.rem_zero (rem_zero)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= start_ch.start_value;
		end
		unique case (ctrl.op)
			OP_INIT_CAND: cand_q <= NPS_VW'(start_q + 32'd1);
			OP_INC_CAND:  cand_q <= cand_q + NPS_VW'(1);
			OP_SET_D5:    d_q    <= NPS_D_FIRST;
			OP_ADD_D6:    d_q    <= d_q + NPS_D_STEP;
			OP_SQ:        sq_q   <= sq_d;
			default: ;
		endcase
		if (out_we) begin
			unique case (ctrl.op)
				OP_EMIT_PRIME: begin
					prime_q <= 32'(cand_q);
					ovf_q   <= 1'b0;
				end
				OP_EMIT_TWO: begin
					prime_q <= 32'd2;
					ovf_q   <= 1'b0;
				end
				default: begin
					prime_q <= '0;
					ovf_q   <= 1'b1;
				end
			endcase
		end
	end

	// result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_we) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.next_prime = prime_q;
	assign result_ch.overflow   = ovf_q;

	assign flags.no_in          = !start_ch.valid;
	assign flags.start_le1      = (start_q <= 32'd1);
	assign flags.start_ge_bound = (start_q >= NPS_BOUND);
	assign flags.cand_le3       = (cand_q <= NPS_SMALL_PRIME_MAX);
	assign flags.cand_even      = !cand_q[0];
	assign flags.cand_mod3_zero = nps_mod3_zero(32'(cand_q));
	assign flags.cand_at_bound  = (cand_q == NPS_BOUND[NPS_VW-1:0]);
	assign flags.div_busy       = div_busy;
	assign flags.rem_zero       = rem_zero;
	assign flags.sq_gt          = (sq_q > NPS_SQW'(cand_q));
	assign flags.out_full       = out_full;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |-> !div_busy)
		else $error("divide started while remainder unit busy");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !out_we)
		else $error("result written straight after accepting an item");

	a_prime_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_we && ctrl.op == OP_EMIT_PRIME) |-> (cand_q[0] && cand_q >= NPS_VW'(3)))
		else $error("even or tiny candidate reported as prime");
endmodule

>>> bench/next_prime_search_unit_tb.sv
`timescale 1ns / 1ps
module next_prime_search_unit_tb;

	localparam int IDLE_LIMIT  = 1_000_000;
	localparam int DRAIN_WAIT  = 200;
	localparam int RANDOM_ITEMS = 100;

	typedef struct {
		logic [31:0] start_value;
		logic [31:0] next_prime;
		logic        overflow;
	} prime_answer_t;

	logic clk;
	logic arst_n;

	nps_in_if  start_ch();
	nps_out_if result_ch();

	next_prime_search_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_ch  (start_ch.sink),
		.result_ch (result_ch.source)
	);

	logic [31:0]   pending_starts[$];
	prime_answer_t expected_primes[$];
	int            total_starts;
	int            starts_sent;
	int            error_count;
	int            idle_cycles;
	int            phase;
	int            send_idle_pct;
	int            stall_pct;
	logic          start_taken;

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	function automatic bit trial_division_prime(input logic [63:0] n);
		logic [63:0] d;
		if (n <= 64'd1)
			return 1'b0;
		if (n <= 64'd3)
			return 1'b1;
		if (n % 64'd2 == 64'd0 || n % 64'd3 == 64'd0)
			return 1'b0;
		for (d = 64'd5; d <= n / d; d += 64'd6) begin
			if (n % d == 64'd0 || n % (d + 64'd2) == 64'd0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic prime_answer_t next_prime_above(input logic [31:0] start_value);
		prime_answer_t answer;
		logic [63:0]   bound;
		logic [63:0]   cand;
		bound              = 64'(nps_pkg::NPS_BOUND);
		answer.start_value = start_value;
		answer.next_prime  = 32'd0;
		answer.overflow    = 1'b1;
		if (start_value <= 32'd1) begin
			answer.next_prime = 32'd2;
			answer.overflow   = 1'b0;
			return answer;
		end
		if (64'(start_value) < bound) begin
			for (cand = 64'(start_value) + 64'd1; cand <= bound; cand++) begin
				if (trial_division_prime(cand)) begin
					answer.next_prime = cand[31:0];
					answer.overflow   = 1'b0;
					return answer;
				end
			end
		end
		return answer;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		error_count++;
	endtask

	// item driver and ready pattern, both moved at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			phase = (total_starts == 0) ? 0 : starts_sent * 4 / total_starts;
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 64;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 64;
				end
				default: begin
					send_idle_pct = 15;
					stall_pct     = 15;
				end
			endcase
			if (!start_ch.valid || start_taken) begin
				if (pending_starts.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					start_ch.valid       <= 1'b1;
					start_ch.start_value <= pending_starts.pop_front();
					starts_sent          <= starts_sent + 1;
				end else begin
					start_ch.valid <= 1'b0;
				end
			end
			result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		prime_answer_t want;
		start_taken <= start_ch.valid && start_ch.ready;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_primes.size() == 0) begin
					report_mismatch($sformatf("unexpected item next_prime=%0d overflow=%0b",
						result_ch.next_prime, result_ch.overflow));
				end else begin
					want = expected_primes.pop_front();
					if (result_ch.next_prime !== want.next_prime)
						report_mismatch($sformatf("start %0d: next_prime %0d, want %0d",
							want.start_value, result_ch.next_prime, want.next_prime));
					if (result_ch.overflow !== want.overflow)
						report_mismatch($sformatf("start %0d: overflow %0b, want %0b",
							want.start_value, result_ch.overflow, want.overflow));
				end
			end
			if (start_ch.valid && start_ch.ready)
				expected_primes.push_back(next_prime_above(start_ch.start_value));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start_ch.valid && start_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t ns: no item moved for %0d cycles", $time, IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int sel;
		start_ch.valid       = 1'b0;
		start_ch.start_value = 32'd0;
		result_ch.ready      = 1'b0;
		start_taken          = 1'b0;
		starts_sent          = 0;
		total_starts         = 0;
		error_count          = 0;
		idle_cycles          = 0;
		phase                = 0;
		send_idle_pct        = 0;
		stall_pct            = 0;
		arst_n               = 1'b0;

		// small starts, the 2 and 3 shortcut, even and multiple of three rejects
		pending_starts.push_back(32'd0);
		pending_starts.push_back(32'd1);
		pending_starts.push_back(32'd2);
		pending_starts.push_back(32'd3);
		pending_starts.push_back(32'd4);
		pending_starts.push_back(32'd7);
		pending_starts.push_back(32'd8);
		// divisor loop: squares of trial divisors and a long prime gap
		pending_starts.push_back(32'd23);
		pending_starts.push_back(32'd48);
		pending_starts.push_back(32'd120);
		pending_starts.push_back(32'd168);
		pending_starts.push_back(32'd113);
		pending_starts.push_back(32'd65520);
		pending_starts.push_back(32'd65535);
		pending_starts.push_back(32'd1048576);
		// top of the range: no prime fits
		pending_starts.push_back(32'hFFFF_FFFF);
		pending_starts.push_back(32'hFFFF_FFFE);
		pending_starts.push_back(32'd4294967291);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 58)
				pending_starts.push_back($urandom_range(0, 4095));
			else if (sel < 88)
				pending_starts.push_back($urandom_range(0, 262143));
			else if (sel < 96)
				pending_starts.push_back($urandom_range(0, 4194303));
			else
				pending_starts.push_back(32'hFFFF_FFFE + 32'($urandom_range(0, 1)));
		end
		total_starts = pending_starts.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_starts.size() != 0 || start_ch.valid || expected_primes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> files.f
rtl/nps_pkg.sv
rtl/nps_in_if.sv
rtl/nps_out_if.sv
rtl/nps_rem_unit.sv
rtl/nps_useq.sv
rtl/nps_datapath.sv
rtl/next_prime_search_unit.sv
bench/next_prime_search_unit_tb.sv
